### sv/fat_directory_entry_parser_core_defines.svh
// Assertion macros shared by the FAT directory entry parser RTL.
// Needs a clk_i and an active-low rst_ni in the including module.
`ifndef FAT_DIRECTORY_ENTRY_PARSER_CORE_DEFINES_SVH
`define FAT_DIRECTORY_ENTRY_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define FDEP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fdep assertion failed");

// Next-cycle implication.
`define FDEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fdep assertion failed");

`endif

### sv/fdep_pkg.sv
// Types and constants for the FAT directory entry parser.
// No dependencies.
package fdep_pkg;

  localparam int unsigned EntryBytes = 32;
  localparam int unsigned IdxW       = 5;

  localparam logic [7:0] EndMark     = 8'h00;
  localparam logic [7:0] DeletedMark = 8'hE5;
  localparam logic [7:0] LfnAttr     = 8'h0F;
  localparam logic [7:0] AsciiSpace  = 8'h20;
  localparam logic [7:0] AsciiDot    = 8'h2E;
  localparam logic [7:0] AsciiDel    = 8'd127;
  localparam int unsigned VolBit     = 3;
  localparam int unsigned DirBit     = 4;

  typedef struct packed {
    logic [7:0] dir_byte;
    logic       last_of_dir;
  } fdep_in_t;

  typedef struct packed {
    logic        entry_valid;
    logic [63:0] name_text;
    logic [3:0]  name_length;
    logic [23:0] ext_text;
    logic [1:0]  ext_length;
    logic [7:0]  attributes;
    logic        is_directory;
    logic [15:0] first_cluster;
    logic [31:0] file_size;
    logic        dir_done;
  } fdep_out_t;

  // Per-word status from the collector to the top level.
  typedef struct packed {
    logic entry_done;
    logic dir_last;
  } fdep_step_t;

  function automatic logic [7:0] fdep_printable(input logic [7:0] b);
    fdep_printable = (b >= AsciiSpace && b < AsciiDel) ? b : AsciiDot;
  endfunction

endpackage

### sv/fdep_eval.sv
// Combinational check and field extraction of one complete 32-byte entry.
// Depends on fdep_pkg.
module fdep_eval
  import fdep_pkg::*;
(
  input  logic [7:0] entry_i [EntryBytes],
  output logic       keep_o,
  output fdep_out_t  res_o
);

  logic [7:0] nm [8];
  logic [7:0] ex [3];
  logic [3:0] nlen;
  logic [1:0] elen;
  logic [7:0] attr;

  always_comb begin
    attr = entry_i[11];
    for (int i = 0; i < 8; i++) begin
      nm[i] = fdep_printable(entry_i[i]);
    end
    for (int i = 0; i < 3; i++) begin
      ex[i] = fdep_printable(entry_i[8 + i]);
    end
    // trim: length is one past the last non-space character
    nlen = '0;
    for (int i = 0; i < 8; i++) begin
      if (nm[i] != AsciiSpace) nlen = 4'(i + 1);
    end
    elen = '0;
    for (int i = 0; i < 3; i++) begin
      if (ex[i] != AsciiSpace) elen = 2'(i + 1);
    end

    keep_o = (entry_i[0] != DeletedMark) && !attr[VolBit] && (attr != LfnAttr) &&
             (nlen != 4'd0) &&
             !((nlen == 4'd1) && (nm[0] == AsciiDot)) &&
             !((nlen == 4'd2) && (nm[0] == AsciiDot) && (nm[1] == AsciiDot));

    res_o = '0;
    res_o.entry_valid = 1'b1;
    for (int i = 0; i < 8; i++) begin
      res_o.name_text[8*i +: 8] = (4'(i) < nlen) ? nm[i] : 8'h00;
    end
    for (int i = 0; i < 3; i++) begin
      res_o.ext_text[8*i +: 8] = (2'(i) < elen) ? ex[i] : 8'h00;
    end
    res_o.name_length   = nlen;
    res_o.ext_length    = elen;
    res_o.attributes    = attr;
    res_o.is_directory  = attr[DirBit];
    res_o.first_cluster = {entry_i[27], entry_i[26]};
    res_o.file_size     = {entry_i[31], entry_i[30], entry_i[29], entry_i[28]};
  end

endmodule

### sv/fdep_collect.sv
// Position counter, end-of-directory flag and byte storage of the current entry.
// Depends on fdep_pkg.
module fdep_collect
  import fdep_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  fdep_in_t   word_i,
  output logic [7:0] entry_o [EntryBytes],
  output fdep_step_t step_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(EntryBytes - 1);

  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic            end_seen_q, end_seen_d;
  logic [7:0]      entry_q [EntryBytes-1];
  logic            store;

  always_comb begin
    byte_index_d = byte_index_q;
    end_seen_d   = end_seen_q;
    store        = 1'b0;
    if (!end_seen_q) begin
      if (byte_index_q == '0 && word_i.dir_byte == EndMark) begin
        end_seen_d = 1'b1;
      end else begin
        store        = (byte_index_q != LastIdx);
        byte_index_d = byte_index_q + 1'b1;
      end
    end
    // block ends: drop any partial entry
    if (word_i.last_of_dir) begin
      byte_index_d = '0;
      end_seen_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      end_seen_q   <= 1'b0;
    end else if (fire_i) begin
      byte_index_q <= byte_index_d;
      end_seen_q   <= end_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && store) begin
      entry_q[byte_index_q] <= word_i.dir_byte;
    end
  end

  // final byte of an entry comes straight from the input word
  always_comb begin
    for (int i = 0; i < EntryBytes - 1; i++) begin
      entry_o[i] = entry_q[i];
    end
    entry_o[EntryBytes-1] = word_i.dir_byte;
  end

  assign step_o.entry_done = !end_seen_q && (byte_index_q == LastIdx);
  assign step_o.dir_last   = word_i.last_of_dir;

endmodule

### sv/fat_directory_entry_parser_core.sv
// FAT 8.3 directory entry parser: input word register, entry collector and
// evaluator, result register. An accepted word is held in the input word register,
// passes once through the evaluator and lands in the result register; one byte is
// accepted every cycle while the result side keeps up.
// Reset (asynchronous, active low) empties both registers and clears the
// entry position and end-of-directory flag; stored entry bytes are not cleared.
`include "fat_directory_entry_parser_core_defines.svh"

module fat_directory_entry_parser_core
  import fdep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fdep_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output fdep_out_t out_data_o
);

  logic       s1_valid_q;
  fdep_in_t   s1_word_q;
  logic       out_valid_q;
  fdep_out_t  out_q;
  logic       fire;
  logic       keep;
  logic       produce;
  fdep_out_t  eval_res;
  fdep_out_t  res_d;
  fdep_step_t step;
  logic [7:0] entry [EntryBytes];

  // advance the held word once the result register can take its output
  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_word_q <= in_data_i;
    end
  end

  fdep_collect u_collect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .word_i  (s1_word_q),
    .entry_o (entry),
    .step_o  (step)
  );

  fdep_eval u_eval (
    .entry_i (entry),
    .keep_o  (keep),
    .res_o   (eval_res)
  );

  always_comb begin
    res_d          = (step.entry_done && keep) ? eval_res : '0;
    res_d.dir_done = step.dir_last;
    produce        = step.dir_last || (step.entry_done && keep);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && produce) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FDEP_ASSERT_NOW(a_result_has_cause, out_valid_o,
                   out_data_o.entry_valid || out_data_o.dir_done)
  `FDEP_ASSERT_NOW(a_kept_name_len, out_valid_o && out_data_o.entry_valid,
                   out_data_o.name_length != 4'd0 && out_data_o.name_length <= 4'd8)
  `FDEP_ASSERT_NOW(a_empty_fields_zero, out_valid_o && !out_data_o.entry_valid,
                   out_data_o.name_length == 4'd0 && out_data_o.file_size == '0)
  `FDEP_ASSERT_NEXT(a_hold_when_blocked, s1_valid_q && out_valid_o && !out_ready_i,
                    s1_valid_q && out_valid_o)

endmodule

### tb/fat_entry_checker.sv
// Watches both word channels of the FAT directory entry parser, predicts each result
// word and compares it field by field with what the block delivers.
// Depends on fdep_pkg for the word types and the directory constants.
module fat_entry_checker
  import fdep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  fdep_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  fdep_out_t out_data_i,
  output int        mismatch_o,
  output int        pending_o
);

  // Shadow of the parser state.
  logic [IdxW-1:0] pos;
  logic [7:0]      ent [EntryBytes];
  logic            dir_ended;

  fdep_out_t expected_words [$];
  fdep_out_t want, pred;

  task automatic report_error(input string msg);
    mismatch_o++;
    $display("%0t: result mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) begin
      report_error($sformatf("%s got %0h, want %0h", field, got, exp_val));
    end
  endtask

  function automatic logic [7:0] to_text_char(input logic [7:0] b);
    return (b >= 8'd32 && b <= 8'd126) ? b : AsciiDot;
  endfunction

  // Advance the shadow state by one byte; return 1 when a result word is due.
  function automatic bit parse_byte(input fdep_in_t w, output fdep_out_t r);
    logic [7:0] nm [8];
    logic [7:0] ex [3];
    logic [7:0] attr;
    int         i, nlen, elen;
    bit         kept;
    r    = '0;
    kept = 1'b0;
    if (!dir_ended) begin
      if (pos == '0 && w.dir_byte == EndMark) begin
        dir_ended = 1'b1;
      end else begin
        ent[pos] = w.dir_byte;
        if (pos == IdxW'(EntryBytes - 1)) begin
          attr = ent[11];
          for (i = 0; i < 8; i++) nm[i] = to_text_char(ent[i]);
          for (i = 0; i < 3; i++) ex[i] = to_text_char(ent[8 + i]);
          nlen = 8;
          while (nlen > 0 && nm[nlen - 1] == AsciiSpace) nlen--;
          elen = 3;
          while (elen > 0 && ex[elen - 1] == AsciiSpace) elen--;
          kept = !(ent[0] == DeletedMark || attr[VolBit] || attr == LfnAttr || nlen == 0 ||
                   (nlen == 1 && nm[0] == AsciiDot) ||
                   (nlen == 2 && nm[0] == AsciiDot && nm[1] == AsciiDot));
          if (kept) begin
            r.entry_valid = 1'b1;
            for (i = 0; i < nlen; i++) r.name_text[8*i +: 8] = nm[i];
            for (i = 0; i < elen; i++) r.ext_text[8*i +: 8] = ex[i];
            r.name_length   = 4'(nlen);
            r.ext_length    = 2'(elen);
            r.attributes    = attr;
            r.is_directory  = attr[DirBit];
            r.first_cluster = {ent[27], ent[26]};
            r.file_size     = {ent[31], ent[30], ent[29], ent[28]};
          end
        end
        pos = pos + 1'b1;
      end
    end
    if (w.last_of_dir) begin
      r.dir_done = 1'b1;
      kept       = 1'b1;
      pos        = '0;
      dir_ended  = 1'b0;
    end
    return kept;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos       = '0;
      dir_ended = 1'b0;
      expected_words.delete();
      mismatch_o = 0;
      pending_o  = 0;
    end else begin
      // Check the delivered word before queuing a new prediction.
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_error("result word with nothing expected");
        end else begin
          want = expected_words.pop_front();
          check_field("entry_valid", out_data_i.entry_valid, want.entry_valid);
          check_field("name_text", out_data_i.name_text, want.name_text);
          check_field("name_length", out_data_i.name_length, want.name_length);
          check_field("ext_text", out_data_i.ext_text, want.ext_text);
          check_field("ext_length", out_data_i.ext_length, want.ext_length);
          check_field("attributes", out_data_i.attributes, want.attributes);
          check_field("is_directory", out_data_i.is_directory, want.is_directory);
          check_field("first_cluster", out_data_i.first_cluster, want.first_cluster);
          check_field("file_size", out_data_i.file_size, want.file_size);
          check_field("dir_done", out_data_i.dir_done, want.dir_done);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (parse_byte(in_data_i, pred)) expected_words.push_back(pred);
      end
      pending_o = expected_words.size();
    end
  end

endmodule

### tb/tb.sv
// Top of the FAT directory entry parser testbench: clock, reset, byte stimulus,
// result-side back-pressure, watchdog and verdict.
// Depends on fdep_pkg, fat_directory_entry_parser_core and fat_entry_checker.
module tb;
  import fdep_pkg::*;

  localparam int RandomBytes = 650;
  localparam int CalmBytes   = 150;
  localparam int HoldCycles  = 100;
  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  fdep_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  fdep_out_t out_data;
  int        mismatches;
  int        pending;

  bit         sender_gaps;
  bit         receiver_stalls;
  bit         hold_req;
  int         bytes_sent;
  int         quiet_cycles;
  logic [7:0] ent_buf [EntryBytes];

  fat_directory_entry_parser_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  fat_entry_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .mismatch_o (mismatches),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offer one byte at a falling edge; return right after the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{dir_byte: b, last_of_dir: last};
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_entry_buf(input bit last_at_end);
    int i;
    for (i = 0; i < EntryBytes; i++) send_byte(ent_buf[i], last_at_end && i == EntryBytes - 1);
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Name and extension padded with spaces; the reserved bytes are random.
  task automatic fill_entry(input string nm, input string ex, input logic [7:0] attr,
                            input logic [15:0] clus, input logic [31:0] size);
    int i;
    for (i = 0; i < 8; i++) ent_buf[i] = (i < nm.len()) ? nm[i] : AsciiSpace;
    for (i = 0; i < 3; i++) ent_buf[8 + i] = (i < ex.len()) ? ex[i] : AsciiSpace;
    ent_buf[11] = attr;
    for (i = 12; i < 26; i++) ent_buf[i] = 8'($urandom);
    {ent_buf[27], ent_buf[26]} = clus;
    {ent_buf[31], ent_buf[30], ent_buf[29], ent_buf[28]} = size;
  endtask

  // Mostly well-formed entries, some skipped kinds, some raw noise.
  task automatic random_entry();
    int i, kind, nlen, elen, dots;
    kind = $urandom_range(0, 9);
    for (i = 0; i < EntryBytes; i++) ent_buf[i] = 8'($urandom);
    if (kind < 8) begin
      nlen = $urandom_range(1, 8);
      elen = $urandom_range(0, 3);
      for (i = 0; i < 8; i++) ent_buf[i] = (i < nlen) ? 8'($urandom_range(32, 126)) : AsciiSpace;
      for (i = 0; i < 3; i++) begin
        ent_buf[8 + i] = (i < elen) ? 8'($urandom_range(32, 126)) : AsciiSpace;
      end
      ent_buf[0] = 8'($urandom_range(33, 126));
      if ($urandom_range(0, 3) == 0) ent_buf[$urandom_range(0, 10)] = 8'($urandom);
      ent_buf[11][VolBit] = 1'b0;
      case (kind)
        5: ent_buf[0] = DeletedMark;
        6: begin
          if ($urandom_range(0, 1) == 0) ent_buf[11] = LfnAttr;
          else ent_buf[11][VolBit] = 1'b1;
        end
        7: begin
          dots = $urandom_range(0, 2);
          for (i = 0; i < 8; i++) ent_buf[i] = (i < dots) ? AsciiDot : AsciiSpace;
        end
        default: ;
      endcase
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] odd_name [11];
    int         i, k, n, m, target;
    odd_name = '{8'h01, 8'h7F, 8'hFF, 8'h80, 8'h7E, 8'h20, 8'h41, 8'h20, 8'h1F, 8'h20, 8'h20};
    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    hold_req        = 1'b0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    bytes_sent      = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes and every kind of entry.
    fill_entry("README", "TXT", 8'h20, 16'h0002, 32'h0000_1234);
    send_entry_buf(1'b0);
    fill_entry("ABCDEFGH", "XYZ", 8'h10, 16'hFFFF, 32'hFFFF_FFFF);
    send_entry_buf(1'b0);
    fill_entry("A", "", 8'h00, 16'h0000, 32'h0000_0000);
    send_entry_buf(1'b0);
    fill_entry("GONE", "TMP", 8'h20, 16'h0001, 32'h0000_0001);
    ent_buf[0] = DeletedMark;
    send_entry_buf(1'b0);
    fill_entry("MYDISK", "", 8'h08, 16'h0000, 32'h0000_0000);
    send_entry_buf(1'b0);
    fill_entry("LONGNAM", "EXT", LfnAttr, 16'h1234, 32'h0000_0040);
    send_entry_buf(1'b0);
    fill_entry("", "TXT", 8'h20, 16'h0003, 32'h0000_0003);
    send_entry_buf(1'b0);
    fill_entry(".", "", 8'h10, 16'h0005, 32'h0000_0000);
    send_entry_buf(1'b0);
    fill_entry("..", "", 8'h10, 16'h0000, 32'h0000_0000);
    send_entry_buf(1'b0);
    fill_entry("...", "", 8'h10, 16'h0007, 32'h0000_0000);
    send_entry_buf(1'b0);
    fill_entry("", "", 8'h21, 16'h8000, 32'h8000_0000);
    for (i = 0; i < 11; i++) ent_buf[i] = odd_name[i];
    send_entry_buf(1'b0);
    // A lone unprintable name character reads as a dot entry.
    fill_entry("", "", 8'h20, 16'h0009, 32'h0000_0009);
    ent_buf[0] = 8'h05;
    send_entry_buf(1'b0);
    fill_entry("VOLALL", "", 8'hFF, 16'h0000, 32'h0000_0000);
    send_entry_buf(1'b0);
    fill_entry("SUBDIR", "D", 8'hF7, 16'hA5A5, 32'h5A5A_5A5A);
    send_entry_buf(1'b1);

    // Trailing partial entry, then the end marker with bytes behind it.
    fill_entry("PART", "BIN", 8'h20, 16'h0000, 32'h0000_0000);
    for (i = 0; i < 10; i++) send_byte(ent_buf[i], i == 9);
    fill_entry("LAST", "DAT", 8'h01, 16'h0010, 32'h0000_0100);
    send_entry_buf(1'b0);
    send_byte(EndMark, 1'b0);
    for (i = 0; i < 20; i++) send_byte(8'($urandom), i == 19);
    send_byte(EndMark, 1'b1);
    send_byte(8'h41, 1'b1);

    // Hold the result side long enough for the block to back up.
    hold_req = 1'b1;
    fill_entry("HELD", "A", 8'h02, 16'h0042, 32'h0000_0042);
    send_entry_buf(1'b0);
    repeat (8) send_byte(8'($urandom), 1'b1);
    wait_until_drained();

    target = bytes_sent + RandomBytes;
    while (bytes_sent < target) begin
      if (bytes_sent < target - CalmBytes) begin
        sender_gaps     = $urandom_range(0, 3) != 0;
        receiver_stalls = $urandom_range(0, 3) != 0;
      end else begin
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
      end
      n = $urandom_range(1, 4);
      for (k = 0; k < n - 1; k++) begin
        random_entry();
        send_entry_buf(1'b0);
      end
      random_entry();
      case ($urandom_range(0, 3))
        0: send_entry_buf(1'b1);
        1: begin
          m = $urandom_range(1, 31);
          for (i = 0; i < m; i++) send_byte(ent_buf[i], i == m - 1);
        end
        2: begin
          send_entry_buf(1'b0);
          m = $urandom_range(0, 40);
          send_byte(EndMark, m == 0);
          for (i = 0; i < m; i++) send_byte(8'($urandom), i == m - 1);
        end
        default: begin
          send_entry_buf(1'b0);
          send_byte(8'($urandom), 1'b1);
        end
      endcase
    end

    wait_until_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/fdep_pkg.sv
sv/fdep_eval.sv
sv/fdep_collect.sv
sv/fat_directory_entry_parser_core.sv
tb/fat_entry_checker.sv
tb/tb.sv
